@@ rtl/atilt_pkg.sv @@
// package with shared widths, angle constants and the cordic arctangent table
`timescale 1ns / 1ps
package atilt_pkg;

	localparam int AXIS_W  = 16;
	localparam int MAG_W   = 16;
	localparam int PITCH_W = 15;
	localparam int ROLL_W  = 16;
	localparam int ANGLE_W = 35;
	localparam int SQRT_W  = 48;
	localparam int OPND_W  = 25;
	localparam int TAB_LEN = 24;

	localparam longint PI30      = 64'sd3373259426;
	localparam longint HALF_PI30 = 64'sd1686629713;

	function automatic logic signed [ANGLE_W-1:0] atan_tab(input int i);
		logic signed [ANGLE_W-1:0] t;
		case (i)
			0:       t = 35'sd843314856;
			1:       t = 35'sd497837829;
			2:       t = 35'sd263043836;
			3:       t = 35'sd133525158;
			4:       t = 35'sd67021686;
			5:       t = 35'sd33543515;
			6:       t = 35'sd16775850;
			7:       t = 35'sd8388437;
			8:       t = 35'sd4194282;
			9:       t = 35'sd2097149;
			10:      t = 35'sd1048575;
			11:      t = 35'sd524287;
			12:      t = 35'sd262143;
			13:      t = 35'sd131071;
			14:      t = 35'sd65535;
			15:      t = 35'sd32767;
			16:      t = 35'sd16383;
			17:      t = 35'sd8191;
			18:      t = 35'sd4095;
			19:      t = 35'sd2047;
			20:      t = 35'sd1023;
			21:      t = 35'sd511;
			22:      t = 35'sd255;
			23:      t = 35'sd127;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

@@ rtl/atilt_sample_if.sv @@
// interface carrying one accelerometer sample beat
`timescale 1ns / 1ps
interface atilt_sample_if;
	logic                               valid;
	logic                               ready;
	logic signed [atilt_pkg::AXIS_W-1:0] accel_x;
	logic signed [atilt_pkg::AXIS_W-1:0] accel_y;
	logic signed [atilt_pkg::AXIS_W-1:0] accel_z;

	modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
	modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

@@ rtl/atilt_result_if.sv @@
// interface carrying one tilt result beat
`timescale 1ns / 1ps
interface atilt_result_if;
	logic                                valid;
	logic                                ready;
	logic        [atilt_pkg::MAG_W-1:0]   magnitude;
	logic signed [atilt_pkg::PITCH_W-1:0] pitch_angle;
	logic signed [atilt_pkg::ROLL_W-1:0]  roll_angle;
	logic                                zero_vector;

	modport source (output valid, output magnitude, output pitch_angle, output roll_angle,
		output zero_vector, input ready);
	modport sink   (input valid, input magnitude, input pitch_angle, input roll_angle,
		input zero_vector, output ready);
endinterface

@@ rtl/atilt_sqrt_pipe.sv @@
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module atilt_sqrt_pipe #(
	parameter int NW = 48,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_in,
	input  logic [NW-1:0]   n_in,
	input  logic [SW-1:0]   side_in,
	output logic            vld_out,
	output logic [NW/2-1:0] root_out,
	output logic [SW-1:0]   side_out
);
	localparam int RW   = NW / 2;
	localparam int REMW = RW + 3;

	logic [NW-1:0]   n_s    [RW];
	logic [REMW-1:0] rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [SW-1:0]   side_s [RW];
	logic            vld_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [NW-1:0]   p_n;
		logic [REMW-1:0] p_rem;
		logic [RW-1:0]   p_root;
		logic [SW-1:0]   p_side;
		logic            p_vld;
		logic [REMW-1:0] rem_t;
		logic [REMW-1:0] trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign p_n    = n_in;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_side = side_in;
			assign p_vld  = vld_in;
		end else begin : g_next
			assign p_n    = n_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_root = root_s[k-1];
			assign p_side = side_s[k-1];
			assign p_vld  = vld_s[k-1];
		end

		assign rem_t = {p_rem[REMW-3:0], p_n[NW-1 -: 2]};
		assign trial = {1'b0, p_root, 2'b01};
		assign ge    = rem_t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k]    <= {p_n[NW-3:0], 2'b00};
				rem_s[k]  <= ge ? rem_t - trial : rem_t;
				root_s[k] <= {p_root[RW-2:0], ge};
				side_s[k] <= p_side;
			end
		end
	end

	assign vld_out  = vld_s[RW-1];
	assign root_out = root_s[RW-1];
	assign side_out = side_s[RW-1];
endmodule

@@ rtl/atilt_cordic_pipe.sv @@
// pipelined vectoring cordic, quadrant fold then one rotation per stage
`timescale 1ns / 1ps
module atilt_cordic_pipe #(
	parameter int NS = 16,
	parameter int SW = 1
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  logic                                     vld_in,
	input  logic signed [atilt_pkg::OPND_W-1:0]       a_in,
	input  logic signed [atilt_pkg::OPND_W-1:0]       b_in,
	input  logic        [SW-1:0]                     side_in,
	output logic                                     vld_out,
	output logic signed [atilt_pkg::ANGLE_W-1:0]      z_out,
	output logic        [SW-1:0]                     side_out
);
	localparam int IW = atilt_pkg::OPND_W;
	localparam int W  = IW + 19;
	localparam int ZW = atilt_pkg::ANGLE_W;
	localparam logic signed [ZW-1:0] PI_Z = ZW'(atilt_pkg::PI30);

	logic signed [W-1:0]  x_s    [NS+1];
	logic signed [W-1:0]  y_s    [NS+1];
	logic signed [ZW-1:0] z_s    [NS+1];
	logic        [SW-1:0] side_s [NS+1];
	logic                 vld_s  [NS+1];

	logic                 neg_a;
	logic signed [IW-1:0] a_f;
	logic signed [IW-1:0] b_f;

	assign neg_a = a_in[IW-1];
	assign a_f   = neg_a ? -a_in : a_in;
	assign b_f   = neg_a ? -b_in : b_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= {{(W-IW-16){a_f[IW-1]}}, a_f, 16'b0};
			y_s[0]    <= {{(W-IW-16){b_f[IW-1]}}, b_f, 16'b0};
			z_s[0]    <= !neg_a ? '0 : (!b_in[IW-1] ? PI_Z : -PI_Z);
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic                 up;
		logic signed [W-1:0]  dx;
		logic signed [W-1:0]  dy;
		logic signed [ZW-1:0] t;

		assign up = !y_s[k][W-1];
		assign dx = y_s[k] >>> k;
		assign dy = x_s[k] >>> k;
		assign t  = atilt_pkg::atan_tab(k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]    <= up ? x_s[k] + dx : x_s[k] - dx;
				y_s[k+1]    <= up ? y_s[k] - dy : y_s[k] + dy;
				z_s[k+1]    <= up ? z_s[k] + t : z_s[k] - t;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vld_out  = vld_s[NS];
	assign z_out    = z_s[NS];
	assign side_out = side_s[NS];
endmodule

@@ rtl/accel_tilt_angles.sv @@
// top level: accelerometer magnitude, pitch and roll pipeline
//
// usage
//   sample (sink): beats of signed x, y, z counts, valid/ready handshake
//   result (source): magnitude, pitch_angle, roll_angle, zero_vector
//   angles are radians scaled by 2^ANGLE_FRAC_BITS, pitch by atan2(x, |yz|),
//   roll by atan2(y, z); an all-zero sample sets zero_vector, angles 0
// throughput: one beat per cycle, sustained while the receiver takes each result
// pipeline from sample to result, in order:
//   square stage, sum stage, 24 root stages, quadrant fold,
//   cordic rotations, round and clamp stage that holds the result
// the 24-stage square root on the 48-bit radicand sets the depth before
// the cordic
// reset clears all valid bits; no result is pending after reset
// a stalled receiver freezes the whole pipeline; the result register
// holds its beat and sample.ready drops until the result is taken
`timescale 1ns / 1ps
module accel_tilt_angles #(
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int CORDIC_STAGES   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	atilt_sample_if.sink   sample,
	atilt_result_if.source result
);
	localparam int AW = atilt_pkg::AXIS_W;
	localparam int ZW = atilt_pkg::ANGLE_W;
	localparam int NW = atilt_pkg::SQRT_W;
	localparam int RW = NW / 2;
	localparam int IW = atilt_pkg::OPND_W;
	localparam int SH = 30 - ANGLE_FRAC_BITS;
	localparam logic signed [ZW-1:0] LIM_PI  =
		ZW'((atilt_pkg::PI30 + (64'sd1 <<< (SH - 1))) >>> SH);
	localparam logic signed [ZW-1:0] LIM_HPI =
		ZW'((atilt_pkg::HALF_PI30 + (64'sd1 <<< (SH - 1))) >>> SH);
	localparam logic signed [ZW-1:0] RND = ZW'(64'sd1 <<< (SH - 1));

	logic en;
	logic out_vld_q;

	assign en           = !out_vld_q || result.ready;
	assign sample.ready = en;

	logic                 vld_s1;
	logic signed [AW-1:0] x_s1, y_s1, z_s1;
	logic        [30:0]   xx_s1, yy_s1, zz_s1;
	logic signed [31:0]   xx_p, yy_p, zz_p;

	assign xx_p = sample.accel_x * sample.accel_x;
	assign yy_p = sample.accel_y * sample.accel_y;
	assign zz_p = sample.accel_z * sample.accel_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= sample.accel_x;
			y_s1  <= sample.accel_y;
			z_s1  <= sample.accel_z;
			xx_s1 <= xx_p[30:0];
			yy_s1 <= yy_p[30:0];
			zz_s1 <= zz_p[30:0];
		end
	end

	logic                 vld_s2;
	logic signed [AW-1:0] x_s2, y_s2, z_s2;
	logic        [31:0]   yz_s2, ss_s2;
	logic        [31:0]   yz_sum;

	assign yz_sum = {1'b0, yy_s1} + {1'b0, zz_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			z_s2  <= z_s1;
			yz_s2 <= yz_sum;
			ss_s2 <= yz_sum + {1'b0, xx_s1};
		end
	end

	localparam int SQSW = 3 * AW + 1;

	logic            sq_mag_vld, sq_r_vld;
	logic [RW-1:0]   mag_root, r_root;
	logic [SQSW-1:0] sq_side;
	logic            sq_zero;

	atilt_sqrt_pipe #(.NW(NW), .SW(SQSW)) u_sqrt_mag (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_s2),
		.n_in     ({ss_s2, 16'b0}),
		.side_in  ({x_s2, y_s2, z_s2, yz_s2 != '0}),
		.vld_out  (sq_mag_vld),
		.root_out (mag_root),
		.side_out (sq_side)
	);

	atilt_sqrt_pipe #(.NW(NW), .SW(1)) u_sqrt_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_s2),
		.n_in     ({yz_s2, 16'b0}),
		.side_in  (ss_s2 == '0),
		.vld_out  (sq_r_vld),
		.root_out (r_root),
		.side_out (sq_zero)
	);

	logic signed [AW-1:0] sx, sy, sz;
	logic                 syz_nz;
	logic [RW:0]          mag_rnd;
	logic [atilt_pkg::MAG_W-1:0] mag_c;

	assign {sx, sy, sz, syz_nz} = sq_side;
	assign mag_rnd = {1'b0, mag_root} + (RW+1)'(128);
	assign mag_c   = mag_rnd[RW-1:8];

	logic                 cp_vld, cr_vld;
	logic signed [ZW-1:0] cp_z, cr_z;
	logic [atilt_pkg::MAG_W:0] cp_side;
	logic                 cr_zero;

	atilt_cordic_pipe #(.NS(CORDIC_STAGES), .SW(atilt_pkg::MAG_W + 1)) u_cordic_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (sq_mag_vld & sq_r_vld),
		.a_in     ({1'b0, r_root}),
		.b_in     ({sx[AW-1], sx, 8'b0}),
		.side_in  ({mag_c, syz_nz}),
		.vld_out  (cp_vld),
		.z_out    (cp_z),
		.side_out (cp_side)
	);

	atilt_cordic_pipe #(.NS(CORDIC_STAGES), .SW(1)) u_cordic_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (sq_mag_vld & sq_r_vld),
		.a_in     (IW'(sz)),
		.b_in     (IW'(sy)),
		.side_in  (sq_zero),
		.vld_out  (cr_vld),
		.z_out    (cr_z),
		.side_out (cr_zero)
	);

	logic signed [ZW-1:0] p_ang, r_ang, p_clip, r_clip;

	assign p_ang = (cp_z + RND) >>> SH;
	assign r_ang = (cr_z + RND) >>> SH;

	always_comb begin
		if (p_ang > LIM_HPI) begin
			p_clip = LIM_HPI;
		end else if (p_ang < -LIM_HPI) begin
			p_clip = -LIM_HPI;
		end else begin
			p_clip = p_ang;
		end
		if (r_ang > LIM_PI) begin
			r_clip = LIM_PI;
		end else if (r_ang < -LIM_PI) begin
			r_clip = -LIM_PI;
		end else begin
			r_clip = r_ang;
		end
	end

	logic [atilt_pkg::MAG_W-1:0]          mag_q;
	logic signed [atilt_pkg::PITCH_W-1:0] pitch_q;
	logic signed [atilt_pkg::ROLL_W-1:0]  roll_q;
	logic                                 zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= cp_vld & cr_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q   <= cp_side[atilt_pkg::MAG_W:1];
			zero_q  <= cr_zero;
			pitch_q <= cr_zero ? '0 : p_clip[atilt_pkg::PITCH_W-1:0];
			roll_q  <= (cr_zero || !cp_side[0]) ? '0 : r_clip[atilt_pkg::ROLL_W-1:0];
		end
	end

	assign result.valid       = out_vld_q;
	assign result.magnitude   = mag_q;
	assign result.pitch_angle = pitch_q;
	assign result.roll_angle  = roll_q;
	assign result.zero_vector = zero_q;
endmodule

@@ rtl/atilt_checker.sv @@
// port checker for the tilt block and its bind
`timescale 1ns / 1ps
module atilt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] magnitude,
	input logic [14:0] pitch_angle,
	input logic [15:0] roll_angle,
	input logic        zero_vector
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(magnitude) && $stable(pitch_angle)
			&& $stable(roll_angle) && $stable(zero_vector))
		else $error("result beat changed while stalled");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("sample refused with empty output");

	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_vector |-> magnitude == '0 && pitch_angle == '0
			&& roll_angle == '0)
		else $error("zero vector with nonzero result");
endmodule

bind accel_tilt_angles atilt_checker u_atilt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (sample.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.magnitude   (result.magnitude),
	.pitch_angle (result.pitch_angle),
	.roll_angle  (result.roll_angle),
	.zero_vector (result.zero_vector)
);

@@ tb/testbench.sv @@
// testbench for accel_tilt_angles: random and corner samples checked against a tilt predictor
`timescale 1ns / 1ps

typedef struct {
	logic        [atilt_pkg::MAG_W-1:0]   magnitude;
	logic signed [atilt_pkg::PITCH_W-1:0] pitch_angle;
	logic signed [atilt_pkg::ROLL_W-1:0]  roll_angle;
	logic                                zero_vector;
} tilt_t;

class tilt_scoreboard;
	localparam int FRAC   = 13;
	localparam int STAGES = 16;

	tilt_t expected_tilts[$];
	int    errors;

	function new();
		errors = 0;
	endfunction

	function longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned bit_pos;
		root    = 0;
		bit_pos = 64'd1 << 62;
		while (bit_pos > n) bit_pos = bit_pos >> 2;
		while (bit_pos != 0) begin
			if (n >= root + bit_pos) begin
				n    = n - (root + bit_pos);
				root = (root >> 1) + bit_pos;
			end else begin
				root = root >> 1;
			end
			bit_pos = bit_pos >> 2;
		end
		return root;
	endfunction

	function longint round_angle(longint z30);
		return (z30 + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
	endfunction

	function longint vector_angle(longint num, longint den);
		longint ang, xr, yr, dx, dy;
		ang = 0;
		if (den < 0) begin
			ang = (num >= 0) ? atilt_pkg::PI30 : -atilt_pkg::PI30;
			den = -den;
			num = -num;
		end
		xr = den * 65536;
		yr = num * 65536;
		for (int i = 0; i < STAGES; i++) begin
			dx = yr >>> i;
			dy = xr >>> i;
			if (yr >= 0) begin
				xr  = xr + dx;
				yr  = yr - dy;
				ang = ang + longint'(atilt_pkg::atan_tab(i));
			end else begin
				xr  = xr - dx;
				yr  = yr + dy;
				ang = ang - longint'(atilt_pkg::atan_tab(i));
			end
		end
		return round_angle(ang);
	endfunction

	function longint clamp(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function tilt_t predict_tilt(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az);
		tilt_t t;
		longint x, y, z, pitch, roll;
		longint unsigned yz, s, q, r;
		x  = ax;
		y  = ay;
		z  = az;
		yz = y * y + z * z;
		s  = yz + x * x;
		q  = int_sqrt(s);
		if (s - q * q > q) q = q + 1;
		pitch = 0;
		roll  = 0;
		if (s != 0) begin
			r     = int_sqrt(yz << 16);
			pitch = clamp(vector_angle(x * 256, r), round_angle(atilt_pkg::HALF_PI30));
			if (yz != 0)
				roll = clamp(vector_angle(y, z), round_angle(atilt_pkg::PI30));
		end
		t.magnitude   = q[15:0];
		t.pitch_angle = pitch[14:0];
		t.roll_angle  = roll[15:0];
		t.zero_vector = (s == 0);
		return t;
	endfunction

	function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az);
		expected_tilts.push_back(predict_tilt(ax, ay, az));
	endfunction

	task report(string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	task check_result(tilt_t got);
		tilt_t e;
		if (expected_tilts.size() == 0) begin
			report("result beat with nothing pending");
			return;
		end
		e = expected_tilts.pop_front();
		if (got.magnitude !== e.magnitude)
			report($sformatf("magnitude %0d, want %0d", got.magnitude, e.magnitude));
		if (got.pitch_angle !== e.pitch_angle)
			report($sformatf("pitch %0d, want %0d", got.pitch_angle, e.pitch_angle));
		if (got.roll_angle !== e.roll_angle)
			report($sformatf("roll %0d, want %0d", got.roll_angle, e.roll_angle));
		if (got.zero_vector !== e.zero_vector)
			report($sformatf("zero_vector %0b, want %0b", got.zero_vector, e.zero_vector));
	endtask
endclass

module testbench;
	localparam int RANDOM_BEATS = 630;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 200;

	logic clk;
	logic arst_n;
	bit   quiet;
	int   sent;
	int   idle_count;

	atilt_sample_if sample();
	atilt_result_if result();

	tilt_scoreboard sb = new();

	accel_tilt_angles u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample.sink),
		.result (result.source)
	);

	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	task send_beat(logic signed [15:0] ax, logic signed [15:0] ay, logic signed [15:0] az);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 22) begin
			sample.valid <= 1'b0;
			@(negedge clk);
		end
		sample.valid   <= 1'b1;
		sample.accel_x <= ax;
		sample.accel_y <= ay;
		sample.accel_z <= az;
		do @(posedge clk); while (!sample.ready);
		sb.note_sample(ax, ay, az);
		sent++;
	endtask

	function logic signed [15:0] pick_axis(int mode);
		case (mode)
			0:       return 16'($urandom);
			1:       return 16'($urandom_range(600)) - 16'sd300;
			2:       return ($urandom_range(1) == 0) ? 16'sd0 : 16'($urandom);
			default: begin
				case ($urandom_range(4))
					0:       return 16'sh8000;
					1:       return 16'sh7fff;
					2:       return 16'sh0000;
					3:       return -16'sd1;
					default: return 16'sd1;
				endcase
			end
		endcase
	endfunction

	task run_directed();
		send_beat(0, 0, 0);
		send_beat(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_beat(16'sh8000, 16'sh8000, 16'sh8000);
		send_beat(16'sh8000, 0, 0);
		send_beat(16'sh7fff, 0, 0);
		send_beat(1, 0, 0);
		send_beat(-1, 0, 0);
		send_beat(0, 0, 16'sh8000);
		send_beat(0, 16'sd5, -16'sd1);
		send_beat(0, -16'sd5, -16'sd1);
		send_beat(0, 0, -16'sd1);
		send_beat(0, 16'sh7fff, 0);
		send_beat(0, 16'sh8000, 0);
		send_beat(0, 0, 16'sh7fff);
		send_beat(16'sh7fff, 1, 0);
		send_beat(16'sh8000, 0, 1);
		send_beat(100, -100, -100);
		send_beat(-100, 100, -100);
		send_beat(16'sh8000, 16'sh7fff, 16'sh8000);
		send_beat(0, 1, 1);
		send_beat(-1, -1, -1);
	endtask

	initial begin
		int mode;
		arst_n         = 1'b0;
		sample.valid   = 1'b0;
		sample.accel_x = '0;
		sample.accel_y = '0;
		sample.accel_z = '0;
		quiet          = 1'b0;
		sent           = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		run_directed();
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			quiet = (i >= 300 && i < 420);
			mode  = $urandom_range(3);
			send_beat(pick_axis(mode), pick_axis(mode), pick_axis(mode));
		end
		@(negedge clk);
		sample.valid <= 1'b0;
		while (sb.expected_tilts.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// receiver with one long hold-off so the pipeline backs up
	initial begin
		bit held;
		held         = 1'b0;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && sent >= 120) begin
				held = 1'b1;
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				result.ready <= (quiet || $urandom_range(99) >= 22);
			end
		end
	end

	always @(posedge clk) begin
		tilt_t got;
		if (arst_n && result.valid && result.ready) begin
			got.magnitude   = result.magnitude;
			got.pitch_angle = result.pitch_angle;
			got.roll_angle  = result.roll_angle;
			got.zero_vector = result.zero_vector;
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready) || !arst_n)
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end
endmodule
